/* sv/gmp_pkg.sv */
`default_nettype none
package gmp_pkg;

  localparam logic [15:0] PORT_ZERO_ADDR = 16'h4016;
  localparam logic [15:0] PORT_ONE_ADDR  = 16'h4017;
  localparam logic [7:0]  PAD_MARK       = 8'h40;
  localparam logic [7:0]  SIG_BIT        = 8'h01;
  localparam logic [4:0]  SIG_COUNT_ZERO = 5'd19;
  localparam logic [4:0]  SIG_COUNT_ONE  = 5'd18;
  localparam logic [4:0]  LAST_COUNT     = 5'd23;
  localparam logic [4:0]  NEAR_END       = 5'd8;
  localparam logic [4:0]  FAR_END        = 5'd16;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int ITEM_W  = 62;
  localparam int TDATA_W = 64;

  localparam logic [2:0] REG_ZAPPER_ENABLE = 3'd0;

  // first declared member lands in the highest bits
  typedef struct packed {
    logic [4:0]  zapper_bits;
    logic [7:0]  pad_four_buttons;
    logic [7:0]  pad_three_buttons;
    logic [7:0]  pad_two_buttons;
    logic [7:0]  pad_one_buttons;
    logic [7:0]  write_value;
    logic [15:0] address;
    logic        op;
  } gmp_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] count_next;
  } gmp_bit_t;

endpackage
`default_nettype wire

/* sv/gmp_read_unit.sv */
`default_nettype none
module gmp_read_unit
  import gmp_pkg::*;
(
  input  wire logic [4:0] count,
  input  wire logic [7:0] near_pad,
  input  wire logic [7:0] far_pad,
  input  wire logic [4:0] sig_count,
  output gmp_bit_t        result
);

  always_comb begin
    result.data       = 8'h00;
    result.count_next = count + 5'd1;
    if (count >= LAST_COUNT) begin
      result.count_next = 5'd0;
    end else if (count < NEAR_END) begin
      result.data = PAD_MARK | {7'd0, near_pad[count[2:0]]};
    end else if (count < FAR_END) begin
      result.data = PAD_MARK | {7'd0, far_pad[count[2:0]]};
    end else if (count == sig_count) begin
      result.data = SIG_BIT;
    end
  end

endmodule
`default_nettype wire

/* sv/gamepad_multitap_port.sv */
// A transaction sits in the input register; its result goes to the output register.
// Throughput: one transaction per cycle unless stalled; read/strobe logic is single-pass.
// A stalled result waits in the output register while the input register holds one more.
// Reset (rst, synchronous): strobe level, both read counters and zapper_enable
// clear; both register stages empty.
`default_nettype none
module gamepad_multitap_port
  import gmp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // [0] op, [16:1] address, [24:17] write_value, [32:25] pad_one_buttons,
  // [40:33] pad_two_buttons, [48:41] pad_three_buttons,
  // [56:49] pad_four_buttons, [61:57] zapper_bits, [63:62] zero
  input  wire logic [TDATA_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // [7:0] read_data
  output logic [7:0]               m_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic      zapper_enable;
  logic      strobe_level;
  logic      strobe_level_next;
  logic [4:0] port_zero_count;
  logic [4:0] port_zero_count_next;
  logic [4:0] port_one_count;
  logic [4:0] port_one_count_next;

  logic       in_valid;
  gmp_item_t  in_item;
  logic       advance;
  logic [7:0] read_data_next;

  gmp_bit_t   zero_bit;
  gmp_bit_t   one_bit;
  logic       is_zero_port;
  logic       is_one_port;

  assign pready = 1'b1;
  assign prdata = {31'd0, zapper_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      zapper_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_ZAPPER_ENABLE[2]) begin
      zapper_enable <= pwdata[0];
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= gmp_item_t'(s_tdata[ITEM_W-1:0]);
    end
  end

  gmp_read_unit u_zero (
    .count     (port_zero_count),
    .near_pad  (in_item.pad_one_buttons),
    .far_pad   (in_item.pad_three_buttons),
    .sig_count (SIG_COUNT_ZERO),
    .result    (zero_bit)
  );

  gmp_read_unit u_one (
    .count     (port_one_count),
    .near_pad  (in_item.pad_two_buttons),
    .far_pad   (in_item.pad_four_buttons),
    .sig_count (SIG_COUNT_ONE),
    .result    (one_bit)
  );

  assign is_zero_port = in_item.address == PORT_ZERO_ADDR;
  assign is_one_port  = in_item.address == PORT_ONE_ADDR;

  always_comb begin
    strobe_level_next    = strobe_level;
    port_zero_count_next = port_zero_count;
    port_one_count_next  = port_one_count;
    read_data_next       = 8'h00;
    if (in_item.op == OP_WRITE) begin
      if (is_zero_port) begin
        strobe_level_next = in_item.write_value[0];
        if (!in_item.write_value[0] && strobe_level) begin
          port_zero_count_next = 5'd0;
          port_one_count_next  = 5'd0;
        end
      end
    end else if (is_zero_port) begin
      read_data_next       = zero_bit.data;
      port_zero_count_next = zero_bit.count_next;
    end else if (is_one_port) begin
      read_data_next      = one_bit.data |
                            {3'd0, in_item.zapper_bits & {5{zapper_enable}}};
      port_one_count_next = one_bit.count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_level    <= 1'b0;
      port_zero_count <= 5'd0;
      port_one_count  <= 5'd0;
    end else if (advance) begin
      strobe_level    <= strobe_level_next;
      port_zero_count <= port_zero_count_next;
      port_one_count  <= port_one_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= read_data_next;
    end
  end

endmodule
`default_nettype wire

/* sv/gmp_checker.sv */
`default_nettype none
module gmp_checker
  import gmp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic [TDATA_W-1:0] s_tdata,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [7:0]         m_tdata,
  input wire logic [31:0]        prdata,
  input wire logic               pready
);

  // after reset nothing is pending and the register reads back cleared
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && prdata == 32'd0)
    else $error("state not cleared by reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // only serial bit, zapper bits and pad mark can ever be set
  a_data_bits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[5] && !m_tdata[7])
    else $error("read data has impossible bits set");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !$isunknown(s_tdata))
    else $error("accepted transaction carries unknown bits");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind gamepad_multitap_port gmp_checker u_gmp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .prdata   (prdata),
  .pready   (pready)
);
`default_nettype wire
